/* rtl/grw_pkg.sv */
`timescale 1ns / 1ps
package grw_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT = 3'd4;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_ADVANCE = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OUTSIDE = 2'd1;
	localparam logic [1:0] ST_IDLE = 2'd2;

	localparam int BLK_W = 16;
	localparam int IDX_W = 20;
	localparam int DIM_REG_W = 11;
	localparam int SHIFT_W = 4;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic signed [BLK_W-1:0] origin_x;
		logic signed [BLK_W-1:0] origin_y;
		logic [DIM_REG_W-1:0] width;
		logic [DIM_REG_W-1:0] height;
		logic [SHIFT_W-1:0] shift;
	} cfg_t;

endpackage

/* rtl/grw_if.sv */
`timescale 1ns / 1ps
interface grw_cmd_if #(
	parameter int COORD_BITS = 24
);
	logic valid;
	logic ready;
	logic func;
	logic signed [COORD_BITS-1:0] from_x;
	logic signed [COORD_BITS-1:0] from_y;
	logic signed [COORD_BITS-1:0] to_x;
	logic signed [COORD_BITS-1:0] to_y;

	modport source (output valid, func, from_x, from_y, to_x, to_y, input ready);
	modport sink (input valid, func, from_x, from_y, to_x, to_y, output ready);
endinterface

interface grw_res_if;
	logic valid;
	logic ready;
	logic signed [15:0] block_x;
	logic signed [15:0] block_y;
	logic [19:0] block_index;
	logic [1:0] status;
	logic last;

	modport source (output valid, block_x, block_y, block_index, status, last, input ready);
	modport sink (input valid, block_x, block_y, block_index, status, last, output ready);
endinterface

/* rtl/grw_front.sv */
`timescale 1ns / 1ps
module grw_front #(
	parameter int FRAC_BITS = 8,
	parameter int COORD_BITS = 24,
	parameter int ENT_W = 217
) (
	input logic clk,
	input logic arst_n,
	grw_cmd_if.sink cmd,
	input grw_pkg::cfg_t cfg,
	input logic [grw_pkg::QCNT_W-1:0] q_count,
	output logic push,
	output logic [ENT_W-1:0] push_data
);
	localparam int D_W = COORD_BITS + 1;
	localparam int FC_W = FRAC_BITS + 16;
	localparam int P_W = FC_W + D_W;
	localparam int ACC_W = P_W + 1;
	localparam int S_W = $clog2(FRAC_BITS + 16);
	localparam int B_W = grw_pkg::BLK_W;

	typedef struct packed {
		logic func;
		logic signed [B_W-1:0] bx;
		logic signed [B_W-1:0] by;
		logic signed [B_W-1:0] sx;
		logic signed [B_W-1:0] sy;
		logic [1:0] neg;
		logic adx_nz;
		logic ady_nz;
		logic [P_W-1:0] inc_x;
		logic [P_W-1:0] inc_y;
		logic signed [ACC_W-1:0] diff;
	} entry_t;

	function automatic logic [FC_W-1:0] first_cross(
		input logic signed [COORD_BITS-1:0] v,
		input logic [S_W-1:0] s,
		input logic neg
	);
		logic [FC_W-1:0] unit;
		logic [FC_W-1:0] fr;
		unit = FC_W'(1) << s;
		fr = FC_W'(v) & (unit - FC_W'(1));
		return neg ? fr : unit - fr;
	endfunction

	logic [S_W-1:0] span;
	logic signed [D_W-1:0] dx, dy;
	logic [grw_pkg::QCNT_W:0] occupancy;
	logic take;

	// stage 1
	logic v_s1, func_s1, nx_s1, ny_s1;
	logic [D_W-1:0] adx_s1, ady_s1;
	logic [FC_W-1:0] fcx_s1, fcy_s1;
	logic signed [B_W-1:0] bx_s1, by_s1, sx_s1, sy_s1;
	logic [S_W-1:0] span_s1;

	// stage 2
	logic v_s2, func_s2, nx_s2, ny_s2, adx_nz_s2, ady_nz_s2;
	logic [P_W-1:0] prod_x_s2, prod_y_s2, inc_x_s2, inc_y_s2;
	logic signed [B_W-1:0] bx_s2, by_s2, sx_s2, sy_s2;

	entry_t ent;

	assign occupancy = {1'b0, q_count} + (grw_pkg::QCNT_W+1)'(v_s1)
		+ (grw_pkg::QCNT_W+1)'(v_s2);
	assign cmd.ready = occupancy < (grw_pkg::QCNT_W+1)'(grw_pkg::QUEUE_DEPTH);
	assign take = cmd.valid && cmd.ready;

	assign span = S_W'(FRAC_BITS) + S_W'(cfg.shift);
	assign dx = D_W'(cmd.to_x) - D_W'(cmd.from_x);
	assign dy = D_W'(cmd.to_y) - D_W'(cmd.from_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		func_s1 <= cmd.func;
		nx_s1 <= dx[D_W-1];
		ny_s1 <= dy[D_W-1];
		adx_s1 <= dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
		ady_s1 <= dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
		fcx_s1 <= first_cross(cmd.from_x, span, dx[D_W-1]);
		fcy_s1 <= first_cross(cmd.from_y, span, dy[D_W-1]);
		bx_s1 <= B_W'(cmd.from_x >>> span);
		by_s1 <= B_W'(cmd.from_y >>> span);
		sx_s1 <= B_W'(cmd.to_x >>> span);
		sy_s1 <= B_W'(cmd.to_y >>> span);
		span_s1 <= span;

		func_s2 <= func_s1;
		nx_s2 <= nx_s1;
		ny_s2 <= ny_s1;
		adx_nz_s2 <= adx_s1 != '0;
		ady_nz_s2 <= ady_s1 != '0;
		prod_x_s2 <= P_W'(fcx_s1) * P_W'(ady_s1);
		prod_y_s2 <= P_W'(fcy_s1) * P_W'(adx_s1);
		inc_x_s2 <= P_W'(ady_s1) << span_s1;
		inc_y_s2 <= P_W'(adx_s1) << span_s1;
		bx_s2 <= bx_s1;
		by_s2 <= by_s1;
		sx_s2 <= sx_s1;
		sy_s2 <= sy_s1;
	end

	always_comb begin
		ent.func = func_s2;
		ent.bx = bx_s2;
		ent.by = by_s2;
		ent.sx = sx_s2;
		ent.sy = sy_s2;
		ent.neg = {ny_s2, nx_s2};
		ent.adx_nz = adx_nz_s2;
		ent.ady_nz = ady_nz_s2;
		ent.inc_x = inc_x_s2;
		ent.inc_y = inc_y_s2;
		ent.diff = $signed({1'b0, prod_x_s2}) - $signed({1'b0, prod_y_s2});
	end

	assign push = v_s2;
	assign push_data = ent;

endmodule

/* rtl/grw_queue.sv */
`timescale 1ns / 1ps
module grw_queue #(
	parameter int W = 217
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [W-1:0] push_data,
	input logic pop,
	output logic q_valid,
	output logic [W-1:0] q_data,
	output logic [grw_pkg::QCNT_W-1:0] count
);
	logic [W-1:0] mem_q [grw_pkg::QUEUE_DEPTH];
	logic [grw_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [grw_pkg::QCNT_W-1:0] count_q;

	assign q_valid = count_q != '0;
	assign q_data = mem_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + grw_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + grw_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + grw_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - grw_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

/* rtl/grw_back.sv */
`timescale 1ns / 1ps
module grw_back #(
	parameter int FRAC_BITS = 8,
	parameter int COORD_BITS = 24,
	parameter int MAX_GRID_DIM = 1024,
	parameter int ENT_W = 217
) (
	input logic clk,
	input logic arst_n,
	input grw_pkg::cfg_t cfg,
	input logic q_valid,
	input logic [ENT_W-1:0] q_data,
	output logic pop,
	grw_res_if.source res
);
	localparam int D_W = COORD_BITS + 1;
	localparam int FC_W = FRAC_BITS + 16;
	localparam int P_W = FC_W + D_W;
	localparam int ACC_W = P_W + 1;
	localparam int B_W = grw_pkg::BLK_W;
	localparam int RW = $clog2(MAX_GRID_DIM);
	localparam int W_W = $clog2(MAX_GRID_DIM + 1);
	localparam int PW = RW + W_W;

	typedef struct packed {
		logic func;
		logic signed [B_W-1:0] bx;
		logic signed [B_W-1:0] by;
		logic signed [B_W-1:0] sx;
		logic signed [B_W-1:0] sy;
		logic [1:0] neg;
		logic adx_nz;
		logic ady_nz;
		logic [P_W-1:0] inc_x;
		logic [P_W-1:0] inc_y;
		logic signed [ACC_W-1:0] diff;
	} entry_t;

	entry_t ent;

	// walk state
	logic active_q, adx_nz_q, ady_nz_q;
	logic [1:0] neg_q;
	logic signed [B_W-1:0] cur_x_q, cur_y_q, stop_x_q, stop_y_q;
	logic [P_W-1:0] inc_x_q, inc_y_q;
	logic signed [ACC_W-1:0] diff_q;

	// result stage and output register
	logic res_v_s1, res_in_s1, res_last_s1;
	logic signed [B_W-1:0] res_x_s1, res_y_s1;
	logic [RW-1:0] res_rx_s1, res_ry_s1;
	logic [1:0] res_status_s1;

	logic out_v_q, out_last_q;
	logic signed [B_W-1:0] out_x_q, out_y_q;
	logic [grw_pkg::IDX_W-1:0] out_idx_q;
	logic [1:0] out_status_q;

	logic out_adv, s1_take;
	logic is_start, take_x, in_grid, done, emit;
	logic signed [B_W-1:0] vis_x, vis_y, vstop_x, vstop_y;
	logic signed [B_W:0] rx, ry;
	logic [W_W-1:0] w_cl, h_cl;
	logic [PW-1:0] idx_full;

	assign ent = entry_t'(q_data);

	assign out_adv = !out_v_q || res.ready;
	assign s1_take = !res_v_s1 || out_adv;
	assign pop = q_valid && s1_take;

	always_comb begin
		w_cl = (32'(cfg.width) > 32'(MAX_GRID_DIM)) ? W_W'(MAX_GRID_DIM) : W_W'(cfg.width);
		h_cl = (32'(cfg.height) > 32'(MAX_GRID_DIM)) ? W_W'(MAX_GRID_DIM) : W_W'(cfg.height);

		is_start = ent.func == grw_pkg::FUNC_START;
		if (!ady_nz_q) begin
			take_x = adx_nz_q;
		end else if (!adx_nz_q) begin
			take_x = 1'b0;
		end else begin
			take_x = diff_q[ACC_W-1];
		end

		if (is_start) begin
			vis_x = ent.bx;
			vis_y = ent.by;
			vstop_x = ent.sx;
			vstop_y = ent.sy;
		end else begin
			vis_x = cur_x_q;
			vis_y = cur_y_q;
			if (take_x) begin
				vis_x = cur_x_q + (neg_q[0] ? 16'shffff : 16'sh0001);
			end else begin
				vis_y = cur_y_q + (neg_q[1] ? 16'shffff : 16'sh0001);
			end
			vstop_x = stop_x_q;
			vstop_y = stop_y_q;
		end

		rx = (B_W+1)'(vis_x) - (B_W+1)'(cfg.origin_x);
		ry = (B_W+1)'(vis_y) - (B_W+1)'(cfg.origin_y);
		in_grid = !rx[B_W] && !ry[B_W]
			&& ($unsigned(rx) < (B_W+1)'(w_cl)) && ($unsigned(ry) < (B_W+1)'(h_cl));
		done = (vis_x == vstop_x) && (vis_y == vstop_y);
		emit = is_start || active_q;

		idx_full = PW'(res_ry_s1) * PW'(w_cl) + PW'(res_rx_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			adx_nz_q <= 1'b0;
			ady_nz_q <= 1'b0;
			neg_q <= '0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			stop_x_q <= '0;
			stop_y_q <= '0;
			inc_x_q <= '0;
			inc_y_q <= '0;
			diff_q <= '0;
		end else if (pop && emit) begin
			cur_x_q <= vis_x;
			cur_y_q <= vis_y;
			active_q <= in_grid && !done;
			if (is_start) begin
				stop_x_q <= ent.sx;
				stop_y_q <= ent.sy;
				neg_q <= ent.neg;
				adx_nz_q <= ent.adx_nz;
				ady_nz_q <= ent.ady_nz;
				inc_x_q <= ent.inc_x;
				inc_y_q <= ent.inc_y;
				diff_q <= ent.diff;
			end else if (take_x) begin
				diff_q <= diff_q + $signed({1'b0, inc_x_q});
			end else begin
				diff_q <= diff_q - $signed({1'b0, inc_y_q});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_take) begin
				res_v_s1 <= pop;
			end
			if (out_adv) begin
				out_v_q <= res_v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (emit) begin
				res_x_s1 <= vis_x;
				res_y_s1 <= vis_y;
				res_in_s1 <= in_grid;
				res_status_s1 <= in_grid ? grw_pkg::ST_OK : grw_pkg::ST_OUTSIDE;
				res_last_s1 <= !in_grid || done;
			end else begin
				res_x_s1 <= '0;
				res_y_s1 <= '0;
				res_in_s1 <= 1'b0;
				res_status_s1 <= grw_pkg::ST_IDLE;
				res_last_s1 <= 1'b0;
			end
			res_rx_s1 <= RW'(rx);
			res_ry_s1 <= RW'(ry);
		end
		if (out_adv && res_v_s1) begin
			out_x_q <= res_x_s1;
			out_y_q <= res_y_s1;
			out_idx_q <= res_in_s1 ? grw_pkg::IDX_W'(idx_full) : '0;
			out_status_q <= res_status_s1;
			out_last_q <= res_last_s1;
		end
	end

	assign res.valid = out_v_q;
	assign res.block_x = out_x_q;
	assign res.block_y = out_y_q;
	assign res.block_index = out_idx_q;
	assign res.status = out_status_q;
	assign res.last = out_last_q;

endmodule

/* rtl/grid_ray_block_walker.sv */
`timescale 1ns / 1ps
// Grid ray block walker: a start item (func 0) gives a segment's two end points in
// fixed point and answers with the block holding the start point; each advance item
// (func 1) steps one block in DDA order and answers with that block, its row-major
// index, and a status (in grid, left the grid, or no walk active); last marks the
// final beat of a walk. Start and advance items alike are accepted one per cycle
// while the queue has room, and each yields exactly one result beat: two front
// stages form the floors and the first-crossing products (one 24x25 multiplier
// pair), a four-entry queue follows, and the walk unit does one accumulator add
// and compare per cycle unless the output stalls, then the index multiply feeds
// the output register. Configuration is written through cfg_we/cfg_index/cfg_data
// by the user only while the block is idle; the block does not enforce this.
module grid_ray_block_walker #(
	parameter int FRAC_BITS = 8,
	parameter int MAX_GRID_DIM = 1024,
	parameter int COORD_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [grw_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [grw_pkg::CFG_DATA_W-1:0] cfg_data,
	grw_cmd_if.sink cmd_ch,
	grw_res_if.source res_ch
);
	localparam int D_W = COORD_BITS + 1;
	localparam int FC_W = FRAC_BITS + 16;
	localparam int P_W = FC_W + D_W;
	localparam int ACC_W = P_W + 1;
	localparam int ENT_W = 1 + 4 * grw_pkg::BLK_W + 2 + 2 + 2 * P_W + ACC_W;

	grw_pkg::cfg_t cfg_q;

	logic push, pop, q_valid;
	logic [ENT_W-1:0] push_data, q_data;
	logic [grw_pkg::QCNT_W-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.width <= grw_pkg::DIM_REG_W'(1);
			cfg_q.height <= grw_pkg::DIM_REG_W'(1);
			cfg_q.shift <= grw_pkg::SHIFT_W'(6);
		end else if (cfg_we) begin
			unique case (cfg_index)
				grw_pkg::REG_ORIGIN_X: cfg_q.origin_x <= cfg_data;
				grw_pkg::REG_ORIGIN_Y: cfg_q.origin_y <= cfg_data;
				grw_pkg::REG_WIDTH: cfg_q.width <= grw_pkg::DIM_REG_W'(cfg_data);
				grw_pkg::REG_HEIGHT: cfg_q.height <= grw_pkg::DIM_REG_W'(cfg_data);
				grw_pkg::REG_SHIFT: cfg_q.shift <= grw_pkg::SHIFT_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	grw_front #(
		.FRAC_BITS(FRAC_BITS),
		.COORD_BITS(COORD_BITS),
		.ENT_W(ENT_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.cfg(cfg_q),
		.q_count(q_count),
		.push(push),
		.push_data(push_data)
	);

	grw_queue #(
		.W(ENT_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.q_valid(q_valid),
		.q_data(q_data),
		.count(q_count)
	);

	grw_back #(
		.FRAC_BITS(FRAC_BITS),
		.COORD_BITS(COORD_BITS),
		.MAX_GRID_DIM(MAX_GRID_DIM),
		.ENT_W(ENT_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_data(q_data),
		.pop(pop),
		.res(res_ch)
	);

endmodule

/* bench/grid_ray_block_walker_tb.sv */
`timescale 1ns / 1ps
module grid_ray_block_walker_tb;
	import grw_pkg::*;

	localparam int FRAC_BITS = 8;
	localparam int MAX_GRID_DIM = 1024;
	localparam int COORD_BITS = 24;
	localparam int HOLD_CYCLES = 150;
	localparam int MAX_REPORTS = 10;
	localparam int PHASE_ITEMS = 96;

	typedef struct packed {
		logic func;
		logic signed [COORD_BITS-1:0] fx;
		logic signed [COORD_BITS-1:0] fy;
		logic signed [COORD_BITS-1:0] tx;
		logic signed [COORD_BITS-1:0] ty;
	} seg_cmd_t;

	typedef struct packed {
		logic signed [BLK_W-1:0] bx;
		logic signed [BLK_W-1:0] by;
		logic [IDX_W-1:0] idx;
		logic [1:0] status;
		logic last;
	} visit_t;

	typedef struct packed {
		seg_cmd_t c;
		logic typed;
		visit_t want;
	} walk_item_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	grw_cmd_if #(.COORD_BITS(COORD_BITS)) cmd_bus ();
	grw_res_if res_bus ();

	grid_ray_block_walker #(
		.FRAC_BITS(FRAC_BITS),
		.MAX_GRID_DIM(MAX_GRID_DIM),
		.COORD_BITS(COORD_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_ch(cmd_bus),
		.res_ch(res_bus)
	);

	// grid settings as the walker sees them
	logic signed [BLK_W-1:0] grid_org_x = '0;
	logic signed [BLK_W-1:0] grid_org_y = '0;
	logic [DIM_REG_W-1:0] grid_w = 11'd1;
	logic [DIM_REG_W-1:0] grid_h = 11'd1;
	logic [SHIFT_W-1:0] blk_shift = 4'd6;

	// walk state
	logic signed [BLK_W-1:0] at_x = '0;
	logic signed [BLK_W-1:0] at_y = '0;
	logic signed [BLK_W-1:0] goal_x = '0;
	logic signed [BLK_W-1:0] goal_y = '0;
	logic back_x = 1'b0;
	logic back_y = 1'b0;
	longint unsigned span_x = 0;
	longint unsigned span_y = 0;
	longint unsigned side_x = 0;
	longint unsigned side_y = 0;
	logic walking = 1'b0;

	walk_item_t plan_q[$];
	walk_item_t offer;
	visit_t due_q[$];
	logic hold_req = 1'b0;

	int errors = 0;
	int n_start = 0;
	int n_adv = 0;
	int n_ok = 0;
	int n_off = 0;
	int n_idle = 0;
	int n_last = 0;
	int n_settings = 0;

	function automatic longint unsigned cross_dist(longint v, longint unsigned unit_v, logic neg);
		longint unsigned fr;
		fr = longint'(v) & (unit_v - 1);
		return neg ? fr : unit_v - fr;
	endfunction

	function automatic visit_t grid_visit();
		longint w, h, rx, ry;
		visit_t v;
		w = (grid_w > MAX_GRID_DIM) ? MAX_GRID_DIM : grid_w;
		h = (grid_h > MAX_GRID_DIM) ? MAX_GRID_DIM : grid_h;
		rx = longint'(at_x) - longint'(grid_org_x);
		ry = longint'(at_y) - longint'(grid_org_y);
		v.bx = at_x;
		v.by = at_y;
		if (rx >= 0 && ry >= 0 && rx < w && ry < h) begin
			v.idx = IDX_W'(ry * w + rx);
			v.status = ST_OK;
			v.last = (at_x == goal_x) && (at_y == goal_y);
		end else begin
			v.idx = '0;
			v.status = ST_OUTSIDE;
			v.last = 1'b1;
		end
		if (v.last)
			walking = 1'b0;
		return v;
	endfunction

	function automatic visit_t walk_predict(seg_cmd_t c);
		int s;
		longint unsigned unit_v, low;
		longint fx, fy, tx, ty, dx, dy;
		logic take_x;
		visit_t v;
		s = FRAC_BITS + blk_shift;
		unit_v = 64'd1 << s;
		if (c.func == FUNC_START) begin
			fx = longint'($signed(c.fx));
			fy = longint'($signed(c.fy));
			tx = longint'($signed(c.tx));
			ty = longint'($signed(c.ty));
			dx = tx - fx;
			dy = ty - fy;
			back_x = dx < 0;
			back_y = dy < 0;
			span_x = back_x ? -dx : dx;
			span_y = back_y ? -dy : dy;
			at_x = BLK_W'(fx >>> s);
			at_y = BLK_W'(fy >>> s);
			goal_x = BLK_W'(tx >>> s);
			goal_y = BLK_W'(ty >>> s);
			side_x = cross_dist(fx, unit_v, back_x) * span_y;
			side_y = cross_dist(fy, unit_v, back_y) * span_x;
			walking = 1'b1;
			return grid_visit();
		end
		if (!walking) begin
			v = '0;
			v.status = ST_IDLE;
			return v;
		end
		if (span_y == 0)
			take_x = span_x != 0;
		else if (span_x == 0)
			take_x = 1'b0;
		else
			take_x = side_x < side_y;
		if (take_x) begin
			side_x += unit_v * span_y;
			at_x = at_x + (back_x ? -16'sd1 : 16'sd1);
		end else begin
			side_y += unit_v * span_x;
			at_y = at_y + (back_y ? -16'sd1 : 16'sd1);
		end
		low = (side_x < side_y) ? side_x : side_y;
		side_x -= low;
		side_y -= low;
		return grid_visit();
	endfunction

	function automatic visit_t visit(int bx, int by, int idx, logic [1:0] st, logic last);
		visit_t v;
		v.bx = BLK_W'(bx);
		v.by = BLK_W'(by);
		v.idx = IDX_W'(idx);
		v.status = st;
		v.last = last;
		return v;
	endfunction

	function automatic void plan_cmd(logic func, int fx, int fy, int tx, int ty);
		walk_item_t it;
		it.c = {func, COORD_BITS'(fx), COORD_BITS'(fy), COORD_BITS'(tx), COORD_BITS'(ty)};
		it.typed = 1'b0;
		it.want = '0;
		plan_q.push_back(it);
	endfunction

	function automatic void plan_known(logic func, int fx, int fy, int tx, int ty, visit_t v);
		walk_item_t it;
		it.c = {func, COORD_BITS'(fx), COORD_BITS'(fy), COORD_BITS'(tx), COORD_BITS'(ty)};
		it.typed = 1'b1;
		it.want = v;
		plan_q.push_back(it);
	endfunction

	function automatic int pick(int a, int b);
		return a + int'($urandom_range(0, b - a));
	endfunction

	function automatic int clamp(int v, int a, int b);
		return (v < a) ? a : (v > b) ? b : v;
	endfunction

	function automatic int world_at(int blk, int s);
		longint unit_w, frac;
		int k;
		unit_w = longint'(1) << s;
		k = $urandom_range(0, 5);
		frac = (k == 0) ? 0 : (k == 1) ? unit_w - 1 : longint'($urandom) & (unit_w - 1);
		return int'(longint'(blk) * unit_w + frac);
	endfunction

	function automatic void plan_advances(int n);
		for (int i = 0; i < n; i++)
			plan_cmd(FUNC_ADVANCE, $urandom, $urandom, $urandom, $urandom);
	endfunction

	// segment walks on the current grid with random content, plus noise
	task automatic plan_phase(int n, int ox, int oy, int w, int h, int sh);
		int s, lo, hi, xa, xb, ya, yb, bx0, by0, bx1, by1, reach, steps, made, r, we, he;
		s = FRAC_BITS + sh;
		hi = (1 << (COORD_BITS - 1 - s)) - 1;
		lo = -hi - 1;
		we = (w > MAX_GRID_DIM) ? MAX_GRID_DIM : (w == 0) ? 1 : w;
		he = (h > MAX_GRID_DIM) ? MAX_GRID_DIM : (h == 0) ? 1 : h;
		xa = clamp(ox, lo, hi);
		xb = clamp(ox + we - 1, xa, hi);
		ya = clamp(oy, lo, hi);
		yb = clamp(oy + he - 1, ya, hi);
		made = 0;
		while (made < n) begin
			r = $urandom_range(0, 99);
			if (r < 70 || r >= 88) begin
				if (r < 70) begin
					bx0 = pick(xa, xb);
					by0 = pick(ya, yb);
					reach = ($urandom_range(0, 9) == 0) ? 60 : 6;
					bx1 = clamp(bx0 + pick(-reach, reach), xa, xb);
					by1 = clamp(by0 + pick(-reach, reach), ya, yb);
				end else begin
					bx0 = pick(clamp(xa - 4, lo, hi), clamp(xb + 4, lo, hi));
					by0 = pick(clamp(ya - 4, lo, hi), clamp(yb + 4, lo, hi));
					bx1 = pick(clamp(xa - 4, lo, hi), clamp(xb + 4, lo, hi));
					by1 = pick(clamp(ya - 4, lo, hi), clamp(yb + 4, lo, hi));
				end
				plan_cmd(FUNC_START, world_at(bx0, s), world_at(by0, s),
					world_at(bx1, s), world_at(by1, s));
				steps = (bx1 > bx0 ? bx1 - bx0 : bx0 - bx1) + (by1 > by0 ? by1 - by0 : by0 - by1);
				if (steps > 130)
					steps = 130;
				if ($urandom_range(0, 9) == 0)
					steps = $urandom_range(0, steps);
				else
					steps += $urandom_range(0, 1);
				plan_advances(steps);
				made += 1 + steps;
			end else if (r < 80) begin
				plan_cmd(FUNC_START, $urandom, $urandom, $urandom, $urandom);
				steps = $urandom_range(0, 3);
				plan_advances(steps);
				made += 1 + steps;
			end else begin
				steps = $urandom_range(1, 2);
				plan_advances(steps);
				made += steps;
			end
		end
	endtask

	task automatic load_grid(int ox, int oy, int w, int h, int sh);
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			case (i)
			0: begin
				cfg_index <= REG_ORIGIN_X;
				cfg_data <= CFG_DATA_W'(ox);
			end
			1: begin
				cfg_index <= REG_ORIGIN_Y;
				cfg_data <= CFG_DATA_W'(oy);
			end
			2: begin
				cfg_index <= REG_WIDTH;
				cfg_data <= CFG_DATA_W'(w);
			end
			3: begin
				cfg_index <= REG_HEIGHT;
				cfg_data <= CFG_DATA_W'(h);
			end
			default: begin
				cfg_index <= REG_SHIFT;
				cfg_data <= CFG_DATA_W'(sh);
			end
			endcase
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// bursts of beats with random gaps between them
	task automatic send_plan();
		walk_item_t it;
		int burst, gap;
		burst = 0;
		while (plan_q.size() != 0) begin
			if (burst == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					cmd_bus.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
			end
			it = plan_q.pop_front();
			offer <= it;
			cmd_bus.valid <= 1'b1;
			cmd_bus.func <= it.c.func;
			cmd_bus.from_x <= it.c.fx;
			cmd_bus.from_y <= it.c.fy;
			cmd_bus.to_x <= it.c.tx;
			cmd_bus.to_y <= it.c.ty;
			do
				@(posedge clk);
			while (!cmd_bus.ready);
			burst--;
		end
		cmd_bus.valid <= 1'b0;
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (due_q.size() != 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic flag_error(string why, visit_t want, visit_t got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%s: want x=%0d y=%0d idx=%0d st=%0d last=%0d, got x=%0d y=%0d idx=%0d st=%0d last=%0d",
				why, want.bx, want.by, want.idx, want.status, want.last,
				got.bx, got.by, got.idx, got.status, got.last);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", due_q.size());
		$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk) begin : monitor
		visit_t want, got;
		if (cfg_we) begin
			case (cfg_index)
			REG_ORIGIN_X: grid_org_x = cfg_data;
			REG_ORIGIN_Y: grid_org_y = cfg_data;
			REG_WIDTH: grid_w = cfg_data[DIM_REG_W-1:0];
			REG_HEIGHT: grid_h = cfg_data[DIM_REG_W-1:0];
			REG_SHIFT: blk_shift = cfg_data[SHIFT_W-1:0];
			default: ;
			endcase
		end
		if (cmd_bus.valid && cmd_bus.ready) begin
			want = walk_predict({cmd_bus.func, cmd_bus.from_x, cmd_bus.from_y,
				cmd_bus.to_x, cmd_bus.to_y});
			due_q.push_back(offer.typed ? offer.want : want);
			if (cmd_bus.func == FUNC_START)
				n_start++;
			else
				n_adv++;
		end
		if (res_bus.valid && res_bus.ready) begin
			got = {res_bus.block_x, res_bus.block_y, res_bus.block_index, res_bus.status,
				res_bus.last};
			if (due_q.size() == 0) begin
				flag_error("unexpected beat", '0, got);
			end else begin
				want = due_q.pop_front();
				if (got !== want)
					flag_error("mismatch", want, got);
			end
			case (got.status)
			ST_OK: n_ok++;
			ST_OUTSIDE: n_off++;
			default: n_idle++;
			endcase
			if (got.last)
				n_last++;
		end
	end

	// receiver stall patterns, plus a long hold-off on request
	initial begin : receiver
		int mode, mode_left, tick;
		mode = 0;
		mode_left = 0;
		tick = 0;
		res_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_req) begin
				hold_req = 1'b0;
				res_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			case (mode)
			0: res_bus.ready <= 1'b1;
			1: res_bus.ready <= 1'($urandom_range(0, 1));
			2: res_bus.ready <= (tick % 3) == 0;
			default: res_bus.ready <= $urandom_range(0, 9) != 0;
			endcase
		end
	end

	initial begin
		int ox, oy, w, h, sh, lo, hi;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		offer <= '0;
		cmd_bus.valid <= 1'b0;
		cmd_bus.func <= FUNC_START;
		cmd_bus.from_x <= '0;
		cmd_bus.from_y <= '0;
		cmd_bus.to_x <= '0;
		cmd_bus.to_y <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset grid: one block at the origin, 2^14 fixed units per block
		plan_known(FUNC_ADVANCE, 0, 0, 0, 0, visit(0, 0, 0, ST_IDLE, 0));
		plan_known(FUNC_START, 0, 0, 0, 0, visit(0, 0, 0, ST_OK, 1));
		plan_known(FUNC_ADVANCE, -1, -1, -1, -1, visit(0, 0, 0, ST_IDLE, 0));
		plan_known(FUNC_START, -8388608, -8388608, 8388607, 8388607,
			visit(-512, -512, 0, ST_OUTSIDE, 1));
		plan_known(FUNC_ADVANCE, 0, 0, 0, 0, visit(0, 0, 0, ST_IDLE, 0));
		plan_known(FUNC_START, 8388607, 8388607, -8388608, -8388608,
			visit(511, 511, 0, ST_OUTSIDE, 1));
		plan_known(FUNC_START, 100, 200, 20000, 300, visit(0, 0, 0, ST_OK, 0));
		plan_known(FUNC_ADVANCE, 0, 0, 0, 0, visit(1, 0, 0, ST_OUTSIDE, 1));
		plan_known(FUNC_ADVANCE, 0, 0, 0, 0, visit(0, 0, 0, ST_IDLE, 0));
		plan_known(FUNC_START, 16383, 16383, 16383, 16383, visit(0, 0, 0, ST_OK, 1));
		plan_known(FUNC_START, -1, -1, 5, 5, visit(-1, -1, 0, ST_OUTSIDE, 1));
		// zero x delta, boundary starts in both directions, diagonal tie
		plan_cmd(FUNC_START, 5, 5, 5, -40000);
		plan_cmd(FUNC_ADVANCE, 0, 0, 0, 0);
		plan_cmd(FUNC_START, 0, 0, -100, -50);
		plan_cmd(FUNC_ADVANCE, 0, 0, 0, 0);
		plan_cmd(FUNC_START, 0, 0, 100, 50);
		plan_cmd(FUNC_START, 8192, 8192, -8192, -8192);
		plan_cmd(FUNC_ADVANCE, 0, 0, 0, 0);
		plan_cmd(FUNC_START, 100, 100, 40000, 100);
		plan_cmd(FUNC_ADVANCE, 0, 0, 0, 0);
		// restart in the middle of a walk
		plan_cmd(FUNC_START, 100, 100, 100, 100000);
		plan_cmd(FUNC_START, 200, 300, -30000, -30000);
		plan_advances(3);
		send_plan();
		drain();

		for (int p = 0; p < 12; p++) begin
			sh = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 7);
			hi = (1 << (COORD_BITS - 1 - FRAC_BITS - sh)) - 1;
			lo = -hi - 1;
			ox = pick(lo, hi);
			oy = pick(lo, hi);
			w = $urandom_range(1, 40);
			h = $urandom_range(1, 40);
			case (p)
			0: begin
				ox = -32768;
				oy = -32768;
				w = 1024;
				h = 1024;
				sh = 0;
			end
			1: begin
				ox = 31000;
				oy = 31500;
				w = 2047;
				h = 1100;
				sh = 0;
			end
			2: begin
				ox = 32767;
				oy = 32767;
				w = 1;
				h = 1;
				sh = 0;
			end
			3: begin
				ox = -1;
				oy = 0;
				w = 0;
				h = 0;
				sh = 15;
			end
			4: begin
				ox = -8;
				oy = -8;
				w = 16;
				h = 16;
				sh = 12;
			end
			5: begin
				sh = $urandom_range(0, 3);
				hi = (1 << (COORD_BITS - 1 - FRAC_BITS - sh)) - 1;
				ox = pick(-hi - 1, hi);
				oy = pick(-hi - 1, hi);
				w = 1;
				h = 1024;
			end
			default: ;
			endcase
			load_grid(ox, oy, w, h, sh);
			plan_phase(PHASE_ITEMS, ox, oy, w, h, sh);
			if (p == 4 || p == 8)
				hold_req = 1'b1;
			send_plan();
			drain();
		end

		if (due_q.size() != 0) begin
			errors += due_q.size();
			$display("%0d expected results never arrived", due_q.size());
		end
		$display("walker: %0d start and %0d advance beats over %0d grid settings",
			n_start, n_adv, n_settings + 1);
		$display("walker: %0d in grid, %0d off grid, %0d with no walk, %0d walk ends, %0d errors",
			n_ok, n_off, n_idle, n_last, errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

/* filelist.f */
rtl/grw_pkg.sv
rtl/grw_if.sv
rtl/grw_front.sv
rtl/grw_queue.sv
rtl/grw_back.sv
rtl/grid_ray_block_walker.sv
bench/grid_ray_block_walker_tb.sv
